// ----- rtl/sset_pkg.sv -----
package sset_pkg;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

// ----- rtl/sset_mem.sv -----
module sset_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [sset_pkg::KEY_W-1:0]    wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [sset_pkg::KEY_W-1:0]    rdata
);
    import sset_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sorted_set_insert_delete_core.sv -----
// Lookup: binary search over the n stored entries, each probe going through the
//   registered read port of the entry memory.
// Insert and delete then move each entry past the found position, one entry at a time.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: entry count and control cleared; entry memory contents undefined, no clearing pass.
module sorted_set_insert_delete_core #(
    parameter int CAPACITY = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  sset_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output sset_pkg::rsp_t rsp
);
    import sset_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROBE  = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_INS    = 3'd4;
    localparam logic [2:0] S_DEL    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    wvalid_reg, wvalid_next;

    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        waddr_reg, waddr_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [KEY_W-1:0]        mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic [KEY_W-1:0]        mem_rdata;

    logic [CNT_W:0]          mid_sum;
    logic [CNT_W-1:0]        mid_full;
    logic [CNT_W-1:0]        mid_inc;
    logic [CNT_W-1:0]        ptr_inc;
    logic [CNT_W-1:0]        ptr_dec;
    logic [CNT_W+POS_W-1:0]  pos_ext;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    sset_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full  = mid_sum[CNT_W:1];
    assign mid_inc   = mid_reg + 1'b1;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign ptr_dec   = ptr_reg - 1'b1;
    assign pos_ext   = {{POS_W{1'b0}}, pos_reg};
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        wvalid_next    = wvalid_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ptr_next       = ptr_reg;
        hit_next       = hit_reg;
        waddr_next     = waddr_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        rsp_next       = rsp_reg;

        mem_we    = 1'b0;
        mem_waddr = waddr_reg;
        mem_wdata = mem_rdata;
        mem_raddr = mid_full[IDX_W-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.command;
                    key_next   = req.value;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    state_next = (count_reg != '0) ? S_PROBE : S_DECIDE;
                end
            end

            S_PROBE:
            begin
                mem_raddr  = mid_full[IDX_W-1:0];
                mid_next   = mid_full;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if ($signed(mem_rdata) < key_reg)
                begin
                    lo_next = mid_inc;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                if ($signed(mem_rdata) == key_reg)
                begin
                    hit_next = 1'b1;
                end
                state_next = (lo_next < hi_next) ? S_PROBE : S_DECIDE;
            end

            S_DECIDE:
            begin
                pos_next = '0;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_PRESENT;
                            pos_next    = lo_reg;
                            state_next  = S_OUT;
                        end
                        else if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            pos_next    = lo_reg;
                            ptr_next    = count_reg;
                            wvalid_next = 1'b0;
                            state_next  = S_INS;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            pos_next    = lo_reg;
                            ptr_next    = lo_reg;
                            wvalid_next = 1'b0;
                            state_next  = S_DEL;
                        end
                        else
                        begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_OUT;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_FOUND;
                            pos_next    = lo_reg;
                        end
                        else
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        state_next = S_OUT;
                    end
                endcase
            end

            S_INS:
            begin
                // move entry ptr-1 up to ptr, one read and one write per cycle
                if (wvalid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = waddr_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg > lo_reg)
                begin
                    mem_raddr   = ptr_dec[IDX_W-1:0];
                    waddr_next  = ptr_reg[IDX_W-1:0];
                    wvalid_next = 1'b1;
                    ptr_next    = ptr_dec;
                end
                else if (wvalid_reg)
                begin
                    wvalid_next = 1'b0;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = lo_reg[IDX_W-1:0];
                    mem_wdata   = key_reg;
                    count_next  = count_reg + 1'b1;
                    status_next = ST_INSERTED;
                    state_next  = S_OUT;
                end
            end

            S_DEL:
            begin
                // move entry ptr+1 down to ptr
                if (wvalid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = waddr_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_inc < count_reg)
                begin
                    mem_raddr   = ptr_inc[IDX_W-1:0];
                    waddr_next  = ptr_reg[IDX_W-1:0];
                    wvalid_next = 1'b1;
                    ptr_next    = ptr_inc;
                end
                else if (wvalid_reg)
                begin
                    wvalid_next = 1'b0;
                end
                else
                begin
                    count_next  = count_reg - 1'b1;
                    status_next = ST_DELETED;
                    state_next  = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.position    = pos_ext[POS_W-1:0];
                    rsp_next.entry_count = count_ext[COUNT_W-1:0];
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            wvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            wvalid_reg    <= wvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        hit_reg    <= hit_next;
        waddr_reg  <= waddr_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        rsp_reg    <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg < hi_reg))
        else $error("probe with empty search range");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("response raised outside result state");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("entry count changed at transaction start");

endmodule
